### rtl/cle_pkg.sv
// Shared key codes, sequencer state codes and types of the cooked line editor.
package cle_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] state_type;

   localparam byte_type KEY_BS   = 8'h08;
   localparam byte_type KEY_KILL = 8'h15;
   localparam byte_type KEY_NL   = 8'h0A;
   localparam byte_type KEY_EOT  = 8'h04;

   localparam state_type ST_IDLE   = 2'd0;
   localparam state_type ST_READ   = 2'd1;
   localparam state_type ST_SHOW   = 2'd2;
   localparam state_type ST_SINGLE = 2'd3;

endpackage

### rtl/cle_line_ram.sv
// Line store: one write port and one read port with registered read data.
module cle_line_ram #(
   parameter int LINE_BYTES = 64,
   parameter int AW = 6
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  cle_pkg::byte_type    wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output cle_pkg::byte_type    rd_data
);

   cle_pkg::byte_type mem [LINE_BYTES];
   cle_pkg::byte_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/cle_ctrl.sv
// Editing sequencer: fill index, line drain and the result register.
module cle_ctrl #(
   parameter int LINE_BYTES = 64,
   parameter int AW = 6,
   parameter int FW = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 raw_mode,
   input  logic                 cfg_clear,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  cle_pkg::byte_type    req_byte,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output cle_pkg::byte_type    rsp_byte,
   output logic                 rsp_last,
   output logic                 rsp_empty,
   output logic                 wr_en,
   output logic [AW-1:0]        wr_addr,
   output cle_pkg::byte_type    wr_data,
   output logic                 rd_en,
   output logic [AW-1:0]        rd_addr,
   input  cle_pkg::byte_type    rd_data
);

   cle_pkg::state_type state_ff, state_in;
   logic [FW-1:0]      fill_ff, fill_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic               mark_last_ff, mark_last_in;
   logic               raw_pend_ff, raw_pend_in;
   cle_pkg::byte_type  pend_byte_ff, pend_byte_in;
   logic               pend_empty_ff, pend_empty_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cle_pkg::byte_type  rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_empty_ff, rsp_empty_in;

   logic               accept;
   logic               out_free;
   logic               final_byte;
   logic [FW-1:0]      fill_inc;

   assign req_tready = (state_ff == cle_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fill_inc   = fill_ff + FW'(1);
   assign final_byte = ((FW'(idx_ff) + FW'(1)) == fill_ff);

   assign wr_addr = fill_ff[AW-1:0];
   assign wr_data = req_byte;
   assign rd_addr = idx_ff;
   assign rd_en   = (state_ff == cle_pkg::ST_READ);

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      mark_last_in  = mark_last_ff;
      raw_pend_in   = raw_pend_ff;
      pend_byte_in  = pend_byte_ff;
      pend_empty_in = pend_empty_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      wr_en         = 1'b0;

      case (state_ff)
         cle_pkg::ST_IDLE: begin
            if (cfg_clear) begin
               fill_in = '0;
            end
            if (accept) begin
               idx_in        = '0;
               pend_byte_in  = req_byte;
               pend_empty_in = 1'b0;
               raw_pend_in   = 1'b0;
               mark_last_in  = 1'b1;
               if (raw_mode) begin
                  if (fill_ff != '0) begin
                     mark_last_in = 1'b0;
                     raw_pend_in  = 1'b1;
                     state_in     = cle_pkg::ST_READ;
                  end else begin
                     state_in = cle_pkg::ST_SINGLE;
                  end
               end else if (req_byte == cle_pkg::KEY_BS) begin
                  if (fill_ff != '0) begin
                     fill_in = fill_ff - FW'(1);
                  end
               end else if (req_byte == cle_pkg::KEY_KILL) begin
                  fill_in = '0;
               end else if (req_byte == cle_pkg::KEY_EOT) begin
                  if (fill_ff == '0) begin
                     pend_byte_in  = '0;
                     pend_empty_in = 1'b1;
                     state_in      = cle_pkg::ST_SINGLE;
                  end else begin
                     state_in = cle_pkg::ST_READ;
                  end
               end else begin
                  wr_en   = 1'b1;
                  fill_in = fill_inc;
                  if (req_byte == cle_pkg::KEY_NL || fill_inc == FW'(LINE_BYTES)) begin
                     state_in = cle_pkg::ST_READ;
                  end
               end
            end
         end
         cle_pkg::ST_READ: begin
            state_in = cle_pkg::ST_SHOW;
         end
         cle_pkg::ST_SHOW: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = rd_data;
               rsp_last_in  = mark_last_ff && final_byte;
               rsp_empty_in = 1'b0;
               if (final_byte) begin
                  fill_in  = '0;
                  state_in = raw_pend_ff ? cle_pkg::ST_SINGLE : cle_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = cle_pkg::ST_READ;
               end
            end
         end
         cle_pkg::ST_SINGLE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = pend_byte_ff;
               rsp_last_in  = 1'b1;
               rsp_empty_in = pend_empty_ff;
               state_in     = cle_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cle_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cle_pkg::ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      mark_last_ff  <= mark_last_in;
      raw_pend_ff   <= raw_pend_in;
      pend_byte_ff  <= pend_byte_in;
      pend_empty_ff <= pend_empty_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_byte   = rsp_byte_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_empty  = rsp_empty_ff;

endmodule

### rtl/cooked_line_editor.sv
// Cooked console line editor: mode register, line store and editing sequencer.
// An editing word that commits nothing leaves the sequencer idle; the next word may follow at once.
// A committed line drains byte by byte: each byte passes the READ state, set by the line store's
// registered read port, and then the SHOW state. The input is held until the line has drained
// (and the raw byte sent, if a raw word sends a pending line first), longer while rsp_tready is low.
// A raw or end-of-file word on an empty line goes to the SINGLE state, which registers its result.
// Reset (synchronous, active high) clears the mode to cooked, the fill index and the result
// valid; the line store has no clearing pass and its contents stay undefined.
module cooked_line_editor #(
   parameter int LINE_BYTES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_byte[7:0]
   output logic        rsp_tlast,
   output logic        rsp_tuser    // empty_line
);

   localparam int AW = $clog2(LINE_BYTES);
   localparam int FW = $clog2(LINE_BYTES + 1);

   logic              raw_mode_ff, raw_mode_in;
   logic              cfg_write;
   logic              cfg_clear;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   cle_pkg::byte_type wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   cle_pkg::byte_type rd_data;

   assign csr_ready   = 1'b1;
   assign cfg_write   = csr_valid && csr_ready;
   assign cfg_clear   = cfg_write && !csr_data;
   assign raw_mode_in = cfg_write ? csr_data : raw_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_mode_ff <= 1'b0;
      end else begin
         raw_mode_ff <= raw_mode_in;
      end
   end

   cle_line_ram #(
      .LINE_BYTES (LINE_BYTES),
      .AW         (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cle_ctrl #(
      .LINE_BYTES (LINE_BYTES),
      .AW         (AW),
      .FW         (FW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .raw_mode   (raw_mode_ff),
      .cfg_clear  (cfg_clear),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_byte   (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_byte   (rsp_tdata),
      .rsp_last   (rsp_tlast),
      .rsp_empty  (rsp_tuser),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

endmodule
